// ===== hdl/fhlm_pkg.sv =====
package fhlm_pkg;

  localparam int NUM_LOCKS = 16;
  localparam int NUM_PROCS = 16;
  localparam int LOCK_W = $clog2(NUM_LOCKS);
  localparam int PROC_W = $clog2(NUM_PROCS);

  // Word layouts of the two state memories.
  localparam int LK_W = PROC_W + PROC_W + PROC_W;   // owner, head, tail
  localparam int PR_W = LOCK_W + PROC_W;            // wait lock, next

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_ACQUIRE = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_DESTROY = 3'd3,
    CMD_REMOVE  = 3'd4
  } cmd_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ERR   = 2'd1;
  localparam logic [1:0] STAT_BLOCK = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ACQ2,
    S_POP,
    S_DPOP,
    S_DEND,
    S_RM1,
    S_RMCHK,
    S_RMEND
  } state_t;

endpackage

// ===== hdl/fifo_handoff_lock_manager.sv =====
// Lock table with a FIFO wait queue per lock, one command word at a time.
// Create, acquire and plain release give their word from the execute state;
// release with a waiter adds a pop state that hands the lock on, remove reads
// the lock, walks the queue and ends in a final word, and destroy gives one
// word per waiter and a final word. A new command is taken in the idle state
// after the last step; an acquire that joins a non-empty queue adds a link step.
// Synchronous active-low reset clears all flags; memory contents stay undefined.
module fifo_handoff_lock_manager
  import fhlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [LOCK_W-1:0] in_lock_id,
  input  logic [PROC_W-1:0] in_pid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [LOCK_W-1:0] out_result_lock,
  output logic              out_woken_valid,
  output logic [PROC_W-1:0] out_woken_pid,
  output logic              out_woken_error,
  output logic              out_last
);

  state_t state_r, state_nxt;

  // Per-lock and per-process flags, cleared at reset.
  logic [NUM_LOCKS-1:0] use_r, use_nxt;
  logic [NUM_LOCKS-1:0] held_r, held_nxt;
  logic [NUM_LOCKS-1:0] ne_r, ne_nxt;
  logic [NUM_PROCS-1:0] wait_r, wait_nxt;
  logic [NUM_PROCS-1:0] nv_r, nv_nxt;

  // Latched command and walk registers.
  logic [2:0]        cmd_r;
  logic [LOCK_W-1:0] lid_r;
  logic [PROC_W-1:0] pid_r;
  logic [PROC_W-1:0] cur_r, cur_nxt;
  logic [LOCK_W-1:0] wl_r, wl_nxt;
  logic [PROC_W-1:0] pnext_r, pnext_nxt;

  // Memory ports.
  logic              lk_we, lk_re, pr_we, pr_re;
  logic [LOCK_W-1:0] lk_wa, lk_ra;
  logic [PROC_W-1:0] pr_wa, pr_ra;
  logic [LK_W-1:0]   lk_wd, lk_rd;
  logic [PR_W-1:0]   pr_wd, pr_rd;
  logic [PROC_W-1:0] q_owner, q_head, q_tail, q_next;
  logic [LOCK_W-1:0] q_wlock;

  // Result word being formed.
  logic              emit;
  logic [1:0]        e_status;
  logic [LOCK_W-1:0] e_lock;
  logic              e_wv;
  logic [PROC_W-1:0] e_wp;
  logic              e_we;
  logic              e_last;
  logic              can_emit;

  // Lowest free slot.
  logic              free_found;
  logic [LOCK_W-1:0] free_idx;

  assign {q_owner, q_head, q_tail} = lk_rd;
  assign {q_wlock, q_next} = pr_rd;
  assign can_emit = !out_valid || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  fhlm_ram #(.WIDTH(LK_W), .DEPTH(NUM_LOCKS)) u_lock_ram (
    .clk(clk), .we(lk_we), .wa(lk_wa), .wd(lk_wd),
    .re(lk_re), .ra(lk_ra), .rd(lk_rd)
  );

  fhlm_ram #(.WIDTH(PR_W), .DEPTH(NUM_PROCS)) u_proc_ram (
    .clk(clk), .we(pr_we), .wa(pr_wa), .wd(pr_wd),
    .re(pr_re), .ra(pr_ra), .rd(pr_rd)
  );

  // Priority search for the lowest slot not in use.
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
      if (!use_r[i]) begin
        free_found = 1'b1;
        free_idx = LOCK_W'(i);
      end
    end
  end

  // Sequencer. It never reads a memory in a cycle in which it writes one,
  // so no forwarding is needed between write-back and the next read.
  always_comb begin
    state_nxt = state_r;
    use_nxt = use_r;
    held_nxt = held_r;
    ne_nxt = ne_r;
    wait_nxt = wait_r;
    nv_nxt = nv_r;
    cur_nxt = cur_r;
    wl_nxt = wl_r;
    pnext_nxt = pnext_r;
    lk_we = 1'b0;
    lk_wa = lid_r;
    lk_wd = lk_rd;
    lk_re = 1'b0;
    lk_ra = in_lock_id;
    pr_we = 1'b0;
    pr_wa = pid_r;
    pr_wd = pr_rd;
    pr_re = 1'b0;
    pr_ra = in_pid;
    emit = 1'b0;
    e_status = STAT_OK;
    e_lock = lid_r;
    e_wv = 1'b0;
    e_wp = '0;
    e_we = 1'b0;
    e_last = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        lk_re = in_valid;
        pr_re = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_CREATE: begin
              emit = 1'b1;
              if (free_found) begin
                use_nxt[free_idx] = 1'b1;
                held_nxt[free_idx] = 1'b0;
                ne_nxt[free_idx] = 1'b0;
                e_lock = free_idx;
              end else begin
                e_status = STAT_ERR;
                e_lock = '0;
              end
            end
            CMD_ACQUIRE: begin
              emit = 1'b1;
              if (!use_r[lid_r] || wait_r[pid_r] || (held_r[lid_r] && q_owner == pid_r)) begin
                e_status = STAT_ERR;
              end else if (!held_r[lid_r]) begin
                held_nxt[lid_r] = 1'b1;
                lk_we = 1'b1;
                lk_wd = {pid_r, q_head, q_tail};
              end else begin
                // Queue the caller at the tail.
                e_status = STAT_BLOCK;
                wait_nxt[pid_r] = 1'b1;
                nv_nxt[pid_r] = 1'b0;
                pr_we = 1'b1;
                pr_wa = pid_r;
                pr_wd = {lid_r, {PROC_W{1'b0}}};
                lk_we = 1'b1;
                if (ne_r[lid_r]) begin
                  lk_wd = {q_owner, q_head, pid_r};
                  cur_nxt = q_tail;
                  state_nxt = S_ACQ2;
                end else begin
                  lk_wd = {q_owner, pid_r, pid_r};
                  ne_nxt[lid_r] = 1'b1;
                end
              end
            end
            CMD_RELEASE: begin
              if (!use_r[lid_r] || !held_r[lid_r] || q_owner != pid_r) begin
                emit = 1'b1;
                e_status = STAT_ERR;
              end else if (ne_r[lid_r]) begin
                pr_re = 1'b1;
                pr_ra = q_head;
                state_nxt = S_POP;
              end else begin
                emit = 1'b1;
                held_nxt[lid_r] = 1'b0;
              end
            end
            CMD_DESTROY: begin
              if (!use_r[lid_r]) begin
                emit = 1'b1;
                e_status = STAT_ERR;
              end else if (ne_r[lid_r]) begin
                pr_re = 1'b1;
                pr_ra = q_head;
                cur_nxt = q_head;
                state_nxt = S_DPOP;
              end else begin
                state_nxt = S_DEND;
              end
            end
            CMD_REMOVE: begin
              if (!wait_r[pid_r]) begin
                emit = 1'b1;
                e_status = STAT_ERR;
                e_lock = '0;
                nv_nxt[pid_r] = 1'b0;
              end else begin
                lk_re = 1'b1;
                lk_ra = q_wlock;
                wl_nxt = q_wlock;
                pnext_nxt = q_next;
                state_nxt = S_RM1;
              end
            end
            default: begin
              emit = 1'b1;
              e_status = STAT_ERR;
              e_lock = '0;
            end
          endcase
        end
      end

      // Link the old tail to the newly queued process.
      S_ACQ2: begin
        pr_we = 1'b1;
        pr_wa = cur_r;
        pr_wd = {lid_r, pid_r};
        nv_nxt[cur_r] = 1'b1;
        state_nxt = S_IDLE;
      end

      // Hand the lock to the head waiter.
      S_POP: begin
        if (can_emit) begin
          emit = 1'b1;
          e_wv = 1'b1;
          e_wp = q_head;
          lk_we = 1'b1;
          if (nv_r[q_head]) begin
            lk_wd = {q_head, q_next, q_tail};
          end else begin
            lk_wd = {q_head, q_head, q_tail};
            ne_nxt[lid_r] = 1'b0;
          end
          nv_nxt[q_head] = 1'b0;
          wait_nxt[q_head] = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      // Wake one waiter of a destroyed lock per word.
      S_DPOP: begin
        if (can_emit) begin
          emit = 1'b1;
          e_wv = 1'b1;
          e_wp = cur_r;
          e_we = 1'b1;
          e_last = 1'b0;
          nv_nxt[cur_r] = 1'b0;
          wait_nxt[cur_r] = 1'b0;
          if (nv_r[cur_r]) begin
            pr_re = 1'b1;
            pr_ra = q_next;
            cur_nxt = q_next;
          end else begin
            state_nxt = S_DEND;
          end
        end
      end

      S_DEND: begin
        if (can_emit) begin
          emit = 1'b1;
          ne_nxt[lid_r] = 1'b0;
          held_nxt[lid_r] = 1'b0;
          use_nxt[lid_r] = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      // Remove: the process is at the head, or the walk starts there.
      S_RM1: begin
        if (!ne_r[wl_r]) begin
          state_nxt = S_RMEND;
        end else if (q_head == pid_r) begin
          if (nv_r[pid_r]) begin
            lk_we = 1'b1;
            lk_wa = wl_r;
            lk_wd = {q_owner, pnext_r, q_tail};
          end else begin
            ne_nxt[wl_r] = 1'b0;
          end
          state_nxt = S_RMEND;
        end else begin
          pr_re = 1'b1;
          pr_ra = q_head;
          cur_nxt = q_head;
          state_nxt = S_RMCHK;
        end
      end

      // Walk the queue one entry a cycle, looking for the predecessor.
      S_RMCHK: begin
        if (!nv_r[cur_r]) begin
          state_nxt = S_RMEND;
        end else if (q_next == pid_r) begin
          if (nv_r[pid_r]) begin
            pr_we = 1'b1;
            pr_wa = cur_r;
            pr_wd = {q_wlock, pnext_r};
          end else begin
            nv_nxt[cur_r] = 1'b0;
            lk_we = 1'b1;
            lk_wa = wl_r;
            lk_wd = {q_owner, q_head, cur_r};
          end
          state_nxt = S_RMEND;
        end else begin
          pr_re = 1'b1;
          pr_ra = q_next;
          cur_nxt = q_next;
        end
      end

      S_RMEND: begin
        if (can_emit) begin
          emit = 1'b1;
          e_lock = wl_r;
          nv_nxt[pid_r] = 1'b0;
          wait_nxt[pid_r] = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      use_r <= '0;
      held_r <= '0;
      ne_r <= '0;
      wait_r <= '0;
      nv_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      use_r <= use_nxt;
      held_r <= held_nxt;
      ne_r <= ne_nxt;
      wait_r <= wait_nxt;
      nv_r <= nv_nxt;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_command;
      lid_r <= in_lock_id;
      pid_r <= in_pid;
    end
    cur_r <= cur_nxt;
    wl_r <= wl_nxt;
    pnext_r <= pnext_nxt;
    if (emit) begin
      out_status <= e_status;
      out_result_lock <= e_lock;
      out_woken_valid <= e_wv;
      out_woken_pid <= e_wp;
      out_woken_error <= e_we;
      out_last <= e_last;
    end
  end

endmodule

// ===== hdl/fhlm_ram.sv =====
module fhlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port that holds its word between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== hdl/fhlm_checker.sv =====
module fhlm_checker
  import fhlm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [LOCK_W-1:0] out_result_lock,
  input logic              out_woken_valid,
  input logic [PROC_W-1:0] out_woken_pid,
  input logic              out_woken_error,
  input logic              out_last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_last)
      && $stable(out_result_lock) && $stable(out_woken_pid))
    else $error("stalled result word changed");

  // One command at a time: after acceptance the input side stalls.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command accepted while busy");

  // Only destroy wake-ups are not the final word, and they carry an error.
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_woken_valid && out_woken_error
      && out_status == STAT_OK)
    else $error("non-final word is not a destroy wake-up");

  // No woken process means clean wake fields.
  a_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_woken_valid |-> out_woken_pid == '0 && !out_woken_error)
    else $error("wake fields set without a woken process");

  // A blocked caller never wakes anybody.
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_BLOCK |-> !out_woken_valid && out_last)
    else $error("blocked result with a wake-up");

endmodule

bind fifo_handoff_lock_manager fhlm_checker u_fhlm_checker (.*);
